// ----- rtl/positional_list_store_top_macros.svh -----
// Assertion macros shared by the positional list store checkers.
// Each macro expects clk and arst_n in scope.
`ifndef POSITIONAL_LIST_STORE_TOP_MACROS_SVH
`define POSITIONAL_LIST_STORE_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define PLS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define PLS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/pls_pkg.sv -----
// ----------------------------------------------------------------------------
// pls_pkg
// Types, sizes and codes shared by the positional list store modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pls_pkg;

	// List storage depth and derived widths
	localparam int CAPACITY = 1024;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int LEN_W    = $clog2(CAPACITY + 1);
	localparam int POS_W    = 10;
	localparam int CMP_W    = (LEN_W > POS_W) ? LEN_W : POS_W;
	localparam int DATA_W   = 32;
	localparam int LEN_OUT_W = 11;

	// Read gather tree: cells per group and number of groups
	localparam int GRP_SIZE = 32;
	localparam int NUM_GRP  = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

	// Request function codes
	localparam logic [2:0] FN_READ   = 3'd0;
	localparam logic [2:0] FN_HEAD   = 3'd1;
	localparam logic [2:0] FN_TAIL   = 3'd2;
	localparam logic [2:0] FN_AT     = 3'd3;
	localparam logic [2:0] FN_DELETE = 3'd4;

	// Result status codes
	localparam logic [1:0] ST_DONE   = 2'd0;
	localparam logic [1:0] ST_BADPOS = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;

	typedef struct packed {
		logic [2:0]        func;
		logic [POS_W-1:0]  position;
		logic signed [31:0] item_value;
	} pls_req_t;

	typedef struct packed {
		logic signed [31:0]   read_value;
		logic [1:0]           status;
		logic [LEN_OUT_W-1:0] list_length;
	} pls_rsp_t;

	// Shift control broadcast to every cell
	typedef struct packed {
		logic              ins_en;
		logic              del_en;
		logic [CMP_W-1:0]  pos;
		logic [DATA_W-1:0] item;
	} pls_shift_t;

endpackage

`default_nettype wire

// ----- rtl/pls_cell.sv -----
// ----------------------------------------------------------------------------
// pls_cell
// One list slot. Takes its left neighbor on insert, its right neighbor on
// delete, and drives its value onto the read gather when addressed.
// ----------------------------------------------------------------------------
`default_nettype none

module pls_cell (
	input  wire logic                       clk,
	input  wire pls_pkg::pls_shift_t        ctrl,
	input  wire logic [pls_pkg::IDX_W-1:0]  idx,
	input  wire logic [pls_pkg::DATA_W-1:0] left_val,
	input  wire logic [pls_pkg::DATA_W-1:0] right_val,
	output logic      [pls_pkg::DATA_W-1:0] val,
	output logic      [pls_pkg::DATA_W-1:0] sel
);

	logic [pls_pkg::CMP_W-1:0] idx_ext;
	logic [pls_pkg::DATA_W-1:0] val_q;

	assign idx_ext = pls_pkg::CMP_W'(idx);

	// Shift toward tail on insert, toward head on delete
	always_ff @(posedge clk) begin
		if (ctrl.ins_en) begin
			if (idx_ext > ctrl.pos) begin
				val_q <= left_val;
			end else if (idx_ext == ctrl.pos) begin
				val_q <= ctrl.item;
			end
		end else if (ctrl.del_en) begin
			if (idx_ext >= ctrl.pos) begin
				val_q <= right_val;
			end
		end
	end

	assign val = val_q;

	// Drive value onto the gather only when addressed
	assign sel = (idx_ext == ctrl.pos) ? val_q : '0;

endmodule

`default_nettype wire

// ----- rtl/pls_gather.sv -----
// ----------------------------------------------------------------------------
// pls_gather
// Two-level OR tree that collects the addressed cell's value: groups are
// reduced into registers, then the group registers are reduced.
// ----------------------------------------------------------------------------
`default_nettype none

module pls_gather (
	input  wire logic                       clk,
	input  wire logic [pls_pkg::DATA_W-1:0] sel [pls_pkg::CAPACITY],
	output logic      [pls_pkg::DATA_W-1:0] rd_data
);

	logic [pls_pkg::DATA_W-1:0] grp_d  [pls_pkg::NUM_GRP];
	logic [pls_pkg::DATA_W-1:0] grp_s1 [pls_pkg::NUM_GRP];

	// Reduce each group of cells
	always_comb begin
		for (int g = 0; g < pls_pkg::NUM_GRP; g++) begin
			grp_d[g] = '0;
			for (int k = 0; k < pls_pkg::GRP_SIZE; k++) begin
				if (g * pls_pkg::GRP_SIZE + k < pls_pkg::CAPACITY) begin
					grp_d[g] = grp_d[g] | sel[g * pls_pkg::GRP_SIZE + k];
				end
			end
		end
	end

	// Register group results
	always_ff @(posedge clk) begin
		grp_s1 <= grp_d;
	end

	// Reduce group registers
	always_comb begin
		rd_data = '0;
		for (int g = 0; g < pls_pkg::NUM_GRP; g++) begin
			rd_data = rd_data | grp_s1[g];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/positional_list_store_top.sv -----
// ----------------------------------------------------------------------------
// positional_list_store_top
// Ordered list of signed 32-bit values held in a chain of cells, with read,
// insert (head, tail, before position) and delete by position.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (req_valid/req_ready/req) carries func, position and
//   item_value. The response channel (rsp_valid/rsp_ready/rsp) returns one
//   response per request: read_value, status and the list length after it.
//   One request is in work at a time. An accepted request passes through the
//   sequencer states execute, gather and done, and its response is then
//   loaded into the response register; a new request is taken only once the
//   sequencer is back in idle. Execute decides and shifts the whole chain at
//   once, gather covers the registered group stage of the read gather tree,
//   and done loads the response register.
//   req_ready is high while the sequencer is idle, even when a response
//   still waits in the output register. If the receiver stalls, the
//   finished response of the next request holds in the sequencer until the
//   output register frees.
//   Reset empties the list (length zero), clears rsp_valid, idles the sequencer;
//   cell contents are left as they are and never read before written.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_store_top (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire pls_pkg::pls_req_t req,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output pls_pkg::pls_rsp_t      rsp
);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_EXEC   = 4'b0010,
		S_GATHER = 4'b0100,
		S_DONE   = 4'b1000
	} state_t;

	state_t                     state_q;
	pls_pkg::pls_req_t          req_q;
	logic [pls_pkg::LEN_W-1:0]  length_q;
	logic [1:0]                 status_q;
	logic                       rsp_valid_q;
	pls_pkg::pls_rsp_t          rsp_q;

	logic [pls_pkg::CMP_W-1:0]  pos_ext;
	logic [pls_pkg::CMP_W-1:0]  len_ext;
	logic [pls_pkg::CMP_W-1:0]  where;
	logic                       is_ins;
	logic                       is_del;
	logic [1:0]                 status_d;
	pls_pkg::pls_shift_t        shift;
	logic [pls_pkg::DATA_W-1:0] rd_data;
	logic                       out_free;

	logic [pls_pkg::DATA_W-1:0] cell_val [pls_pkg::CAPACITY];
	logic [pls_pkg::DATA_W-1:0] cell_sel [pls_pkg::CAPACITY];

	assign req_ready = (state_q == S_IDLE);
	assign out_free  = !rsp_valid_q || rsp_ready;

	// Decode the held request against the current length
	assign pos_ext = pls_pkg::CMP_W'(req_q.position);
	assign len_ext = pls_pkg::CMP_W'(length_q);

	always_comb begin
		is_ins   = 1'b0;
		is_del   = 1'b0;
		where    = pos_ext;
		status_d = pls_pkg::ST_BADPOS;
		unique case (req_q.func) inside
			pls_pkg::FN_READ: begin
				status_d = (pos_ext < len_ext) ? pls_pkg::ST_DONE : pls_pkg::ST_BADPOS;
			end
			pls_pkg::FN_HEAD, pls_pkg::FN_TAIL, pls_pkg::FN_AT: begin
				is_ins = 1'b1;
				if (req_q.func == pls_pkg::FN_HEAD) begin
					where = '0;
				end else if (req_q.func == pls_pkg::FN_TAIL) begin
					where = len_ext;
				end
				if (where > len_ext) begin
					status_d = pls_pkg::ST_BADPOS;
				end else if (len_ext >= pls_pkg::CMP_W'(pls_pkg::CAPACITY)) begin
					status_d = pls_pkg::ST_FULL;
				end else begin
					status_d = pls_pkg::ST_DONE;
				end
			end
			pls_pkg::FN_DELETE: begin
				is_del   = 1'b1;
				status_d = (pos_ext < len_ext) ? pls_pkg::ST_DONE : pls_pkg::ST_BADPOS;
			end
			default: begin
				status_d = pls_pkg::ST_BADPOS;
			end
		endcase
	end

	// Broadcast shift control; shift only in the execute cycle
	always_comb begin
		shift.ins_en = (state_q == S_EXEC) && is_ins && (status_d == pls_pkg::ST_DONE);
		shift.del_en = (state_q == S_EXEC) && is_del && (status_d == pls_pkg::ST_DONE);
		shift.pos    = where;
		shift.item   = pls_pkg::DATA_W'(req_q.item_value);
	end

	// Cell chain
	for (genvar i = 0; i < pls_pkg::CAPACITY; i++) begin : g_cell
		logic [pls_pkg::DATA_W-1:0] left_val;
		logic [pls_pkg::DATA_W-1:0] right_val;

		if (i == 0) begin : g_first
			assign left_val = '0;
		end else begin : g_mid_l
			assign left_val = cell_val[i-1];
		end
		if (i == pls_pkg::CAPACITY - 1) begin : g_last
			assign right_val = '0;
		end else begin : g_mid_r
			assign right_val = cell_val[i+1];
		end

		pls_cell u_cell (
			.clk       (clk),
			.ctrl      (shift),
			.idx       (pls_pkg::IDX_W'(i)),
			.left_val  (left_val),
			.right_val (right_val),
			.val       (cell_val[i]),
			.sel       (cell_sel[i])
		);
	end

	pls_gather u_gather (
		.clk     (clk),
		.sel     (cell_sel),
		.rd_data (rd_data)
	);

	// Hold the accepted request
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_q <= req;
		end
	end

	// Sequencer, length and status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			length_q <= '0;
			status_q <= pls_pkg::ST_DONE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					status_q <= status_d;
					if (shift.ins_en) begin
						length_q <= length_q + 1'b1;
					end else if (shift.del_en) begin
						length_q <= length_q - 1'b1;
					end
					state_q <= S_GATHER;
				end
				S_GATHER: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Response register: load when free, drop valid when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			rsp_q.status      <= status_q;
			rsp_q.list_length <= pls_pkg::LEN_OUT_W'(length_q);
			if (req_q.func == pls_pkg::FN_READ && status_q == pls_pkg::ST_DONE) begin
				rsp_q.read_value <= signed'(rd_data);
			end else begin
				rsp_q.read_value <= -32'sd1;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

// ----- rtl/pls_chk.sv -----
// ----------------------------------------------------------------------------
// pls_chk
// Port-level checks for the positional list store, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "positional_list_store_top_macros.svh"

module pls_chk (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              req_valid,
	input wire logic              req_ready,
	input wire pls_pkg::pls_req_t req,
	input wire logic              rsp_valid,
	input wire logic              rsp_ready,
	input wire pls_pkg::pls_rsp_t rsp
);

	// Length never exceeds the storage depth
	`PLS_ASSERT_NOW(a_len_bound, rsp_valid, rsp.list_length <= pls_pkg::LEN_OUT_W'(pls_pkg::CAPACITY), "list length beyond capacity")

	// A failed request never returns data
	`PLS_ASSERT_NOW(a_fail_value, rsp_valid && rsp.status != pls_pkg::ST_DONE, rsp.read_value == -32'sd1, "failed request returned data")

	// A refused insert only happens on a full list
	`PLS_ASSERT_NOW(a_full_len, rsp_valid && rsp.status == pls_pkg::ST_FULL, rsp.list_length == pls_pkg::LEN_OUT_W'(pls_pkg::CAPACITY), "full status on non-full list")

	// A stalled response holds
	`PLS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "stalled response changed")

	// A waiting request holds
	`PLS_ASSERT_NEXT(a_req_hold, req_valid && !req_ready, req_valid && $stable(req), "waiting request changed")

endmodule

bind positional_list_store_top pls_chk u_pls_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

`default_nettype wire
